// ----- hdl/dnsp_pkg.sv -----
// Shared codes and constants for the DNS response parser.
`timescale 1ns / 1ps
`default_nettype none

package dnsp_pkg;

  // Item kinds on the input channel
  localparam logic ACT_ARM  = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  // Result status codes
  typedef logic [3:0] status_t;
  localparam status_t ST_COMPLETE  = 4'd0;
  localparam status_t ST_NOTRESP   = 4'd1;
  localparam status_t ST_BADID     = 4'd2;
  localparam status_t ST_FORMAT    = 4'd3;
  localparam status_t ST_SRVFAIL   = 4'd4;
  localparam status_t ST_NONAME    = 4'd5;
  localparam status_t ST_BADRCODE  = 4'd6;
  localparam status_t ST_NOANSWERS = 4'd7;
  localparam status_t ST_TRUNCATED = 4'd8;

  // Header byte positions
  localparam logic [3:0] HDR_ID_HI    = 4'd0;
  localparam logic [3:0] HDR_ID_LO    = 4'd1;
  localparam logic [3:0] HDR_FLAG_HI  = 4'd2;
  localparam logic [3:0] HDR_FLAG_LO  = 4'd3;
  localparam logic [3:0] HDR_QD_HI    = 4'd4;
  localparam logic [3:0] HDR_QD_LO    = 4'd5;
  localparam logic [3:0] HDR_AN_HI    = 4'd6;
  localparam logic [3:0] HDR_AN_LO    = 4'd7;
  localparam logic [3:0] HDR_LAST     = 4'd11;

  // Resource record fixed-part byte positions
  localparam logic [3:0] RR_TYPE_HI   = 4'd0;
  localparam logic [3:0] RR_TYPE_LO   = 4'd1;
  localparam logic [3:0] RR_RDLEN_HI  = 4'd8;
  localparam logic [3:0] RR_RDLEN_LO  = 4'd9;

  // Rcode values
  localparam logic [3:0] RCODE_OK      = 4'd0;
  localparam logic [3:0] RCODE_FORMAT  = 4'd1;
  localparam logic [3:0] RCODE_SRVFAIL = 4'd2;
  localparam logic [3:0] RCODE_NONAME  = 4'd3;

  localparam logic [15:0] TYPE_A       = 16'd1;
  localparam logic [15:0] A_RDLEN      = 16'd4;
  localparam logic [15:0] QTAIL_LEN    = 16'd4;
  localparam logic [7:0]  PTR_MASK     = 8'hC0;

endpackage

`default_nettype wire

// ----- hdl/dnsp_in_if.sv -----
// Input channel of the DNS response parser: arm items and message bytes.
`timescale 1ns / 1ps
`default_nettype none

interface dnsp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] query_id;
  logic [7:0]  data_byte;
  logic        last_byte;

  modport source (output valid, action, query_id, data_byte, last_byte, input ready);
  modport sink   (input valid, action, query_id, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/dnsp_out_if.sv -----
// Result channel of the DNS response parser.
`timescale 1ns / 1ps
`default_nettype none

interface dnsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] address;
  logic        address_found;

  modport source (output valid, status, address, address_found, input ready);
  modport sink   (input valid, status, address, address_found, output ready);
endinterface

`default_nettype wire

// ----- hdl/dns_response_parser.sv -----
// DNS response parser: byte-wide header, question and answer walk.
//
//   channel  | dir | handshake   | payload
//   in_ch    | in  | valid/ready | action, query_id, data_byte, last_byte
//   out_ch   | out | valid/ready | status, address, address_found
//
// One item per cycle while in_ch.ready is high: an arm item, or a byte while armed,
// updates the parse state in the cycle it is taken, and a last byte then loads the
// result register at the same edge, so out_ch.valid rises in the cycle after it.
// in_ch.ready is low only while a result sits in the output register and
// out_ch.ready is low; a taken result frees the slot in the same cycle.
// Synchronous active-low reset clears the parse state and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module dns_response_parser
  import dnsp_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  dnsp_in_if.sink    in_ch,
  dnsp_out_if.source out_ch
);

  typedef enum logic [3:0] {
    PH_HEADER, PH_QLEN, PH_QLABEL, PH_QTAIL, PH_ANAME, PH_APTR, PH_ALEN,
    PH_ALABEL, PH_AFIXED, PH_AADDR, PH_ARDATA, PH_DONE, PH_ERROR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        waiting_r, waiting_nxt;
  logic [15:0] expected_id_r, expected_id_nxt;
  logic [3:0]  index_r, index_nxt;
  logic [15:0] questions_r, questions_nxt;
  logic [15:0] answers_r, answers_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] field_r, field_nxt;
  logic [15:0] kind_r, kind_nxt;
  status_t     err_r, err_nxt;
  logic [31:0] addr_shift_r, addr_shift_nxt;
  logic [31:0] last_addr_r, last_addr_nxt;
  logic        found_r, found_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic        out_found_r, out_found_nxt;

  logic        in_fire;
  logic        clear_parse;
  logic        load_result;
  logic [7:0]  b;
  logic [15:0] field_cat;
  logic [15:0] skip_dec;
  logic [15:0] ans_dec;
  logic [15:0] q_dec;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign field_cat   = {field_r[7:0], b};
  assign skip_dec    = skip_r - 16'd1;
  assign ans_dec     = answers_r - 16'd1;
  assign q_dec       = questions_r - 16'd1;

  // Advance the parse by one item
  always_comb begin
    phase_nxt      = phase_r;
    waiting_nxt    = waiting_r;
    expected_id_nxt = expected_id_r;
    index_nxt      = index_r;
    questions_nxt  = questions_r;
    answers_nxt    = answers_r;
    skip_nxt       = skip_r;
    field_nxt      = field_r;
    kind_nxt       = kind_r;
    err_nxt        = err_r;
    addr_shift_nxt = addr_shift_r;
    last_addr_nxt  = last_addr_r;
    found_nxt      = found_r;
    clear_parse    = 1'b0;
    load_result    = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_found_nxt  = out_found_r;

    if (in_fire && in_ch.action == ACT_ARM) begin
      expected_id_nxt = in_ch.query_id;
      waiting_nxt     = 1'b1;
      found_nxt       = 1'b0;
      clear_parse     = 1'b1;
    end else if (in_fire && waiting_r) begin
      case (phase_r)
        PH_HEADER: begin
          case (index_r)
            HDR_ID_HI, HDR_FLAG_HI: field_nxt = {8'd0, b};
            HDR_ID_LO: begin
              field_nxt = field_cat;
              if (field_cat != expected_id_r) err_nxt = ST_BADID;
            end
            HDR_FLAG_LO: begin
              field_nxt = field_cat;
              if (!field_cat[15]) begin
                err_nxt   = ST_NOTRESP;
                phase_nxt = PH_ERROR;
              end else if (err_r == ST_BADID) begin
                phase_nxt = PH_ERROR;
              end else if (field_cat[3:0] != RCODE_OK) begin
                phase_nxt = PH_ERROR;
                case (field_cat[3:0])
                  RCODE_FORMAT:  err_nxt = ST_FORMAT;
                  RCODE_SRVFAIL: err_nxt = ST_SRVFAIL;
                  RCODE_NONAME:  err_nxt = ST_NONAME;
                  default:       err_nxt = ST_BADRCODE;
                endcase
              end
            end
            HDR_QD_HI: questions_nxt = {8'd0, b};
            HDR_QD_LO: questions_nxt = {questions_r[7:0], b};
            HDR_AN_HI: answers_nxt = {8'd0, b};
            HDR_AN_LO: begin
              answers_nxt = {answers_r[7:0], b};
              if ({answers_r[7:0], b} == 16'd0) begin
                err_nxt   = ST_NOANSWERS;
                phase_nxt = PH_ERROR;
              end
            end
            default: ;
          endcase
          if (phase_nxt == PH_HEADER) begin
            if (index_r >= HDR_LAST) begin
              phase_nxt = (questions_nxt == 16'd0) ? PH_ANAME : PH_QLEN;
            end else begin
              index_nxt = index_r + 4'd1;
            end
          end
        end
        PH_QLEN: begin
          if (b == 8'd0) begin
            skip_nxt  = QTAIL_LEN;
            phase_nxt = PH_QTAIL;
          end else begin
            skip_nxt  = {8'd0, b};
            phase_nxt = PH_QLABEL;
          end
        end
        PH_QLABEL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) phase_nxt = PH_QLEN;
        end
        PH_QTAIL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            questions_nxt = q_dec;
            phase_nxt     = (q_dec == 16'd0) ? PH_ANAME : PH_QLEN;
          end
        end
        PH_ANAME, PH_ALEN: begin
          if (phase_r == PH_ANAME && (b & PTR_MASK) == PTR_MASK) begin
            phase_nxt = PH_APTR;
          end else if (b == 8'd0) begin
            index_nxt = 4'd0;
            phase_nxt = PH_AFIXED;
          end else begin
            skip_nxt  = {8'd0, b};
            phase_nxt = PH_ALABEL;
          end
        end
        PH_APTR: begin
          index_nxt = 4'd0;
          phase_nxt = PH_AFIXED;
        end
        PH_ALABEL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) phase_nxt = PH_ALEN;
        end
        PH_AFIXED: begin
          case (index_r)
            RR_TYPE_HI: begin
              kind_nxt  = {8'd0, b};
              index_nxt = index_r + 4'd1;
            end
            RR_TYPE_LO: begin
              kind_nxt  = {kind_r[7:0], b};
              index_nxt = index_r + 4'd1;
            end
            RR_RDLEN_HI: begin
              field_nxt = {8'd0, b};
              index_nxt = index_r + 4'd1;
            end
            RR_RDLEN_LO: begin
              field_nxt = field_cat;
              if (kind_r == TYPE_A && field_cat == A_RDLEN) begin
                skip_nxt       = A_RDLEN;
                addr_shift_nxt = 32'd0;
                phase_nxt      = PH_AADDR;
              end else if (field_cat == 16'd0) begin
                answers_nxt = ans_dec;
                phase_nxt   = (ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
              end else begin
                skip_nxt  = field_cat;
                phase_nxt = PH_ARDATA;
              end
            end
            default: index_nxt = index_r + 4'd1;
          endcase
        end
        PH_AADDR: begin
          addr_shift_nxt = {addr_shift_r[23:0], b};
          skip_nxt       = skip_dec;
          if (skip_dec == 16'd0) begin
            last_addr_nxt = {addr_shift_r[23:0], b};
            found_nxt     = 1'b1;
            answers_nxt   = ans_dec;
            phase_nxt     = (ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
          end
        end
        PH_ARDATA: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            answers_nxt = ans_dec;
            phase_nxt   = (ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
          end
        end
        default: ;
      endcase

      // Report on the last byte, then drop back to idle
      if (in_ch.last_byte) begin
        load_result = 1'b1;
        case (phase_nxt)
          PH_DONE:  out_status_nxt = ST_COMPLETE;
          PH_ERROR: out_status_nxt = err_nxt;
          default:  out_status_nxt = ST_TRUNCATED;
        endcase
        out_addr_nxt  = last_addr_nxt;
        out_found_nxt = found_nxt;
        waiting_nxt   = 1'b0;
        found_nxt     = 1'b0;
        clear_parse   = 1'b1;
      end
    end

    if (clear_parse) begin
      phase_nxt      = PH_HEADER;
      index_nxt      = 4'd0;
      questions_nxt  = 16'd0;
      answers_nxt    = 16'd0;
      skip_nxt       = 16'd0;
      field_nxt      = 16'd0;
      kind_nxt       = 16'd0;
      err_nxt        = ST_COMPLETE;
      addr_shift_nxt = 32'd0;
    end

    // Hold a result until taken
    if (load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Parse state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      waiting_r     <= 1'b0;
      expected_id_r <= 16'd0;
      index_r       <= 4'd0;
      questions_r   <= 16'd0;
      answers_r     <= 16'd0;
      skip_r        <= 16'd0;
      field_r       <= 16'd0;
      kind_r        <= 16'd0;
      err_r         <= ST_COMPLETE;
      addr_shift_r  <= 32'd0;
      last_addr_r   <= 32'd0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      waiting_r     <= waiting_nxt;
      expected_id_r <= expected_id_nxt;
      index_r       <= index_nxt;
      questions_r   <= questions_nxt;
      answers_r     <= answers_nxt;
      skip_r        <= skip_nxt;
      field_r       <= field_nxt;
      kind_r        <= kind_nxt;
      err_r         <= err_nxt;
      addr_shift_r  <= addr_shift_nxt;
      last_addr_r   <= last_addr_nxt;
      found_r       <= found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.address       = out_addr_r;
  assign out_ch.address_found = out_found_r;

  // A last byte while waiting always yields a result and ends the wait
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.action == ACT_BYTE && in_ch.last_byte && waiting_r
      |=> out_valid_r && !waiting_r)
    else $error("last byte did not produce a result");

  // Arm restarts the parse
  a_arm_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.action == ACT_ARM
      |=> waiting_r && phase_r == PH_HEADER && index_r == 4'd0 && !found_r)
    else $error("arm did not restart the parse");

  // While idle the parser sits at the header
  a_idle_at_header: assert property (@(posedge clk) disable iff (!rst_n)
    !waiting_r |-> phase_r == PH_HEADER && !found_r)
    else $error("idle parser left the header phase");

  // No item is taken while a stalled result occupies the register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken over a stalled result");

endmodule

`default_nettype wire

// ----- tb/tb_dns_response_parser.sv -----
// Self-checking testbench for the DNS response parser: directed and random messages.
`timescale 1ns / 1ps

module tb_dns_response_parser
  import dnsp_pkg::*;
();

  localparam int CLK_PERIOD   = 10;
  localparam int MAX_WAIT     = 11;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 450;

  // Walk phases of the predictor
  typedef enum logic [3:0] {
    WALK_HEADER, WALK_QLEN, WALK_QLABEL, WALK_QTAIL, WALK_ANAME, WALK_APTR,
    WALK_ALEN, WALK_ALABEL, WALK_AFIXED, WALK_AADDR, WALK_ARDATA, WALK_DONE,
    WALK_ERROR
  } walk_t;

  typedef struct {
    status_t     status;
    logic [31:0] address;
    logic        found;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  dnsp_in_if  in_ch ();
  dnsp_out_if out_ch ();

  dns_response_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state
  logic        armed;
  logic [15:0] want_id;
  walk_t       walk;
  logic [3:0]  pos;
  logic [15:0] questions_left;
  logic [15:0] answers_left;
  logic [15:0] skip_left;
  logic [15:0] field_acc;
  logic [15:0] rr_type;
  status_t     walk_err;
  logic [31:0] addr_acc;
  logic [31:0] held_address;
  logic        found_a;

  reply_t      expected_replies[$];
  logic [7:0]  msg[$];
  int unsigned mismatch_count = 0;
  int unsigned live_items = 0;
  int unsigned cycle_count = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  function automatic void clear_walk();
    walk           = WALK_HEADER;
    pos            = '0;
    questions_left = '0;
    answers_left   = '0;
    skip_left      = '0;
    field_acc      = '0;
    rr_type        = '0;
    walk_err       = ST_COMPLETE;
    addr_acc       = '0;
  endfunction

  function automatic void close_record();
    answers_left = answers_left - 16'd1;
    walk = (answers_left == 16'd0) ? WALK_DONE : WALK_ANAME;
  endfunction

  function automatic void close_question();
    questions_left = questions_left - 16'd1;
    walk = (questions_left == 16'd0) ? WALK_ANAME : WALK_QLEN;
  endfunction

  // Advance the parse by one accepted item; queue a reply on a last byte
  function automatic void predict_item(logic act, logic [15:0] qid, logic [7:0] b,
                                       logic lst);
    reply_t r;
    if (act == ACT_ARM) begin
      want_id = qid;
      armed   = 1'b1;
      found_a = 1'b0;
      clear_walk();
      return;
    end
    if (!armed) return;

    case (walk)
      WALK_HEADER: begin
        case (pos)
          HDR_ID_HI, HDR_FLAG_HI: field_acc = {8'h00, b};
          HDR_ID_LO: begin
            field_acc = {field_acc[7:0], b};
            if (field_acc != want_id) walk_err = ST_BADID;
          end
          HDR_FLAG_LO: begin
            field_acc = {field_acc[7:0], b};
            if (!field_acc[15]) begin
              walk_err = ST_NOTRESP;
              walk = WALK_ERROR;
            end else if (walk_err == ST_BADID) begin
              walk = WALK_ERROR;
            end else if (field_acc[3:0] != RCODE_OK) begin
              case (field_acc[3:0])
                RCODE_FORMAT:  walk_err = ST_FORMAT;
                RCODE_SRVFAIL: walk_err = ST_SRVFAIL;
                RCODE_NONAME:  walk_err = ST_NONAME;
                default:       walk_err = ST_BADRCODE;
              endcase
              walk = WALK_ERROR;
            end
          end
          HDR_QD_HI: questions_left = {8'h00, b};
          HDR_QD_LO: questions_left = {questions_left[7:0], b};
          HDR_AN_HI: answers_left = {8'h00, b};
          HDR_AN_LO: begin
            answers_left = {answers_left[7:0], b};
            if (answers_left == 16'd0) begin
              walk_err = ST_NOANSWERS;
              walk = WALK_ERROR;
            end
          end
          default: ;
        endcase
        if (walk == WALK_HEADER) begin
          if (pos >= HDR_LAST) walk = (questions_left == 16'd0) ? WALK_ANAME : WALK_QLEN;
          else pos = pos + 4'd1;
        end
      end
      WALK_QLEN: begin
        if (b == 8'h00) begin
          skip_left = QTAIL_LEN;
          walk = WALK_QTAIL;
        end else begin
          skip_left = {8'h00, b};
          walk = WALK_QLABEL;
        end
      end
      WALK_QLABEL: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) walk = WALK_QLEN;
      end
      WALK_QTAIL: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) close_question();
      end
      WALK_ANAME, WALK_ALEN: begin
        // only the first byte of an answer name can be a pointer
        if (walk == WALK_ANAME && (b & PTR_MASK) == PTR_MASK) begin
          walk = WALK_APTR;
        end else if (b == 8'h00) begin
          pos = '0;
          walk = WALK_AFIXED;
        end else begin
          skip_left = {8'h00, b};
          walk = WALK_ALABEL;
        end
      end
      WALK_APTR: begin
        pos = '0;
        walk = WALK_AFIXED;
      end
      WALK_ALABEL: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) walk = WALK_ALEN;
      end
      WALK_AFIXED: begin
        if (pos == RR_TYPE_HI) rr_type = {8'h00, b};
        else if (pos == RR_TYPE_LO) rr_type = {rr_type[7:0], b};
        else if (pos == RR_RDLEN_HI) field_acc = {8'h00, b};
        else if (pos == RR_RDLEN_LO) begin
          field_acc = {field_acc[7:0], b};
          if (rr_type == TYPE_A && field_acc == A_RDLEN) begin
            skip_left = A_RDLEN;
            addr_acc = '0;
            walk = WALK_AADDR;
          end else if (field_acc == 16'd0) begin
            close_record();
          end else begin
            skip_left = field_acc;
            walk = WALK_ARDATA;
          end
        end
        if (pos != RR_RDLEN_LO) pos = pos + 4'd1;
      end
      WALK_AADDR: begin
        addr_acc = {addr_acc[23:0], b};
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) begin
          held_address = addr_acc;
          found_a = 1'b1;
          close_record();
        end
      end
      WALK_ARDATA: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) close_record();
      end
      default: ;
    endcase

    if (!lst) return;
    if (walk == WALK_DONE) r.status = ST_COMPLETE;
    else if (walk == WALK_ERROR) r.status = walk_err;
    else r.status = ST_TRUNCATED;
    r.address = held_address;
    r.found   = found_a;
    expected_replies.push_back(r);
    armed   = 1'b0;
    found_a = 1'b0;
    clear_walk();
  endfunction

  // Present one item after a random gap and hold it until taken
  task automatic send_item(input logic act, input logic [15:0] qid,
                           input logic [7:0] b, input logic lst);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.query_id  <= qid;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    do @(posedge clk); while (!in_ch.ready);
    if (act == ACT_ARM || armed) live_items++;
    predict_item(act, qid, b, lst);
  endtask

  task automatic arm_query(input logic [15:0] id);
    send_item(ACT_ARM, id, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_message(input bit mark_last);
    foreach (msg[i])
      send_item(ACT_BYTE, 16'($urandom), msg[i], mark_last && (i == msg.size() - 1));
  endtask

  // Message building helpers
  function automatic void put16(logic [15:0] v);
    msg.push_back(v[15:8]);
    msg.push_back(v[7:0]);
  endfunction

  function automatic void put_random(int count);
    repeat (count) msg.push_back(8'($urandom));
  endfunction

  function automatic void put_header(logic [15:0] id, logic [15:0] flags,
                                     logic [15:0] qd, logic [15:0] an);
    msg.delete();
    put16(id);
    put16(flags);
    put16(qd);
    put16(an);
    put_random(4);
  endfunction

  function automatic void put_labels(int count);
    int len;
    repeat (count) begin
      len = $urandom_range(1, 6);
      msg.push_back(8'(len));
      put_random(len);
    end
    msg.push_back(8'h00);
  endfunction

  function automatic void put_question(int labels);
    put_labels(labels);
    put_random(4);
  endfunction

  function automatic void put_record_tail(logic [15:0] rtype, logic [15:0] rdlen,
                                          logic [31:0] addr);
    put16(rtype);
    put_random(6);
    put16(rdlen);
    if (rtype == TYPE_A && rdlen == A_RDLEN) begin
      put16(addr[31:16]);
      put16(addr[15:0]);
    end else begin
      put_random(rdlen);
    end
  endfunction

  function automatic void put_record(bit ptr, logic [15:0] rtype, logic [15:0] rdlen,
                                     logic [31:0] addr);
    if (ptr) begin
      msg.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
      put_random(1);
    end else begin
      put_labels($urandom_range(0, 2));
    end
    put_record_tail(rtype, rdlen, addr);
  endfunction

  // Bytes with nothing armed are dropped
  task automatic test_idle_bytes();
    send_item(ACT_BYTE, 16'h0000, 8'h00, 1'b1);
    send_item(ACT_BYTE, 16'hFFFF, 8'hFF, 1'b0);
    send_item(ACT_BYTE, 16'h5A5A, PTR_MASK, 1'b1);
  endtask

  // Well-formed responses with A and other records, trailing bytes
  task automatic test_complete_answers();
    arm_query(16'hFFFF);
    put_header(16'hFFFF, 16'h8180, 16'd1, 16'd2);
    put_question(2);
    put_record(1'b1, TYPE_A, A_RDLEN, 32'hFFFF_FFFF);
    put_record(1'b0, 16'h0005, 16'd3, '0);
    msg.push_back(8'h00);
    msg.push_back(8'hFF);
    send_message(1'b1);

    arm_query(16'h0000);
    put_header(16'h0000, 16'h8000, 16'd0, 16'd1);
    put_record(1'b0, TYPE_A, A_RDLEN, 32'h0000_0000);
    send_message(1'b1);

    arm_query(16'h1234);
    put_header(16'h1234, 16'h8180, 16'd1, 16'd1);
    put_question(0);
    put_record(1'b1, 16'h001C, 16'd4, '0);
    send_message(1'b1);
  endtask

  // Each header check, with ignored bytes after the error
  task automatic test_header_errors();
    logic [15:0] flags[8] = '{16'h0103, 16'h8000, 16'h8001, 16'h8002,
                              16'h8003, 16'h8004, 16'h800F, 16'h8180};
    logic [15:0] ids[8]   = '{16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555,
                              16'h5555, 16'h5555, 16'h5555, 16'h5555};
    for (int k = 0; k < 8; k++) begin
      arm_query(16'h5555);
      put_header(ids[k], flags[k], 16'd1, (k == 7) ? 16'd0 : 16'd1);
      put_random(3);
      send_message(1'b1);
    end
  endtask

  // Last byte before the walk is over
  task automatic test_early_end();
    arm_query(16'h0F0F);
    put_header(16'h0F0F, 16'h8180, 16'd1, 16'd1);
    while (msg.size() > 6) void'(msg.pop_back());
    send_message(1'b1);

    arm_query(16'h0F0F);
    put_header(16'h0F0F, 16'h8180, 16'd0, 16'd1);
    send_message(1'b1);

    arm_query(16'h0F0F);
    put_header(16'h0F0F, 16'h8180, 16'd1, 16'd1);
    put_question(3);
    void'(msg.pop_back());
    send_message(1'b1);

    // second A record cut inside its address
    arm_query(16'h0F0F);
    put_header(16'h0F0F, 16'h8180, 16'd0, 16'd2);
    put_record(1'b1, TYPE_A, A_RDLEN, 32'h0A00_0001);
    put_record(1'b1, TYPE_A, A_RDLEN, 32'h0B00_0002);
    void'(msg.pop_back());
    void'(msg.pop_back());
    send_message(1'b1);
  endtask

  // Arm again in the middle of a message
  task automatic test_rearm();
    arm_query(16'h1111);
    put_header(16'h1111, 16'h8180, 16'd0, 16'd1);
    put_record(1'b1, TYPE_A, A_RDLEN, 32'h1111_1111);
    send_message(1'b0);
    arm_query(16'h2222);
    put_header(16'h2222, 16'h8180, 16'd1, 16'd1);
    put_question(1);
    put_record(1'b0, 16'h0010, 16'd2, '0);
    send_message(1'b1);
  endtask

  // Label lengths with the top bits set, odd rdlengths
  task automatic test_long_labels();
    arm_query(16'h7E57);
    put_header(16'h7E57, 16'h8400, 16'd1, 16'd3);
    msg.push_back(8'hFF);
    put_random(255);
    msg.push_back(8'h00);
    put_random(4);
    msg.push_back(8'd3);
    put_random(3);
    msg.push_back(8'hC1);
    put_random(193);
    msg.push_back(8'h00);
    put_record_tail(TYPE_A, A_RDLEN, 32'hC0A8_0101);
    put_record(1'b1, TYPE_A, 16'd5, '0);
    put_record(1'b0, 16'h00FF, 16'd0, '0);
    send_message(1'b1);
  endtask

  // Mostly well-formed responses with random content, some broken or noise
  task automatic test_random_traffic();
    int unsigned items_at_start;
    int          pick;
    logic [15:0] id, flags, qd, an, rtype, rdlen;
    items_at_start = live_items;
    while (live_items - items_at_start < RANDOM_ITEMS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        repeat ($urandom_range(1, 4))
          send_item(ACT_BYTE, 16'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        id = 16'($urandom);
        arm_query(id);
        if (pick < 10) begin
          msg.delete();
          put_random($urandom_range(1, 30));
          send_message(1'b1);
        end else begin
          flags     = 16'($urandom);
          flags[15] = ($urandom_range(0, 12) != 0);
          flags[3:0] = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(1, 15)) : RCODE_OK;
          qd = 16'($urandom_range(0, 2));
          an = ($urandom_range(0, 12) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
          put_header(($urandom_range(0, 9) == 0) ? 16'($urandom) : id, flags, qd, an);
          repeat (qd) put_question($urandom_range(0, 3));
          repeat (an) begin
            rtype = ($urandom_range(0, 2) != 0) ? TYPE_A : 16'($urandom);
            rdlen = (rtype == TYPE_A && $urandom_range(0, 5) != 0) ?
                    A_RDLEN : 16'($urandom_range(0, 6));
            put_record(1'($urandom_range(0, 1)), rtype, rdlen, $urandom);
          end
          if ($urandom_range(0, 4) == 0) put_random($urandom_range(1, 4));
          if ($urandom_range(0, 19) == 0) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
          if ($urandom_range(0, 7) == 0) begin
            pick = $urandom_range(1, msg.size());
            while (msg.size() > pick) void'(msg.pop_back());
          end
          // leave some messages open so the next arm lands mid-message
          send_message($urandom_range(0, 19) != 0);
        end
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Stall the result side at random and compare each taken result
  initial begin
    int     stall;
    reply_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_replies.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d address %h found %b",
                 $time, out_ch.status, out_ch.address, out_ch.address_found);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
          mismatch_count++;
        end
        if (out_ch.address !== want.address) begin
          $display("%0t: address expected %h actual %h", $time, want.address,
                   out_ch.address);
          mismatch_count++;
        end
        if (out_ch.address_found !== want.found) begin
          $display("%0t: address_found expected %b actual %b", $time, want.found,
                   out_ch.address_found);
          mismatch_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dns_response_parser regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_BYTE;
    in_ch.query_id  <= '0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    armed        = 1'b0;
    want_id      = '0;
    held_address = '0;
    found_a      = 1'b0;
    clear_walk();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bytes();
    test_complete_answers();
    test_header_errors();
    test_early_end();
    test_rearm();
    test_long_labels();
    test_idle_bytes();
    test_random_traffic();
    in_ch.valid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("dns_response_parser regression: pass");
    end else begin
      $display("dns_response_parser regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dnsp_pkg.sv
hdl/dnsp_in_if.sv
hdl/dnsp_out_if.sv
hdl/dns_response_parser.sv
tb/tb_dns_response_parser.sv
